FILE: rtl/hpbp_pkg.sv
// ----------------------------------------------------------------------------
// hpbp_pkg
// Shared types and constants of the hashed perceptron branch predictor.
// ----------------------------------------------------------------------------
package hpbp_pkg;

  // Request commands
  localparam logic CMD_PREDICT = 1'b0;
  localparam logic CMD_UPDATE  = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TRAIN_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_MAX      = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WEIGHT_MIN      = 2'd2;
  localparam int unsigned CFG_DATA_BITS = 10;

  // Register field widths and reset values
  localparam int unsigned THRESHOLD_BITS = 10;
  localparam int unsigned WMAX_BITS      = 7;
  localparam int unsigned WMIN_BITS      = 8;
  localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 10'd16;
  localparam logic [WMAX_BITS-1:0]      WMAX_RESET      = 7'd127;
  localparam logic [WMIN_BITS-1:0]      WMIN_RESET      = 8'h80;

  // Hash constants
  localparam logic [63:0] HASH_MUL     = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] CORRECTOR_ID = 64'd99;
  localparam int unsigned HIST_SHL     = 7;
  localparam int unsigned HIST_SHR     = 9;

  // Result sum field
  localparam int unsigned OUT_SUM_BITS = 12;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_we;  // write zero at the sweep address
    logic load;      // capture request and hash indexes
    logic sum_en;    // register the weight sum
    logic commit;    // train, advance history, load result
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // sweep at its final entry
    logic out_free;    // result register can take a new result
  } dp_status_t;

endpackage

FILE: rtl/hpbp_if.sv
// ----------------------------------------------------------------------------
// hpbp interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hpbp_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] branch_address;
  logic        taken;
  modport source (output valid, command, branch_address, taken, input ready);
  modport sink   (input valid, command, branch_address, taken, output ready);
endinterface

interface hpbp_rsp_if;
  logic        valid;
  logic        ready;
  logic        prediction;
  logic signed [11:0] weight_sum;
  logic        trained;
  modport source (output valid, prediction, weight_sum, trained, input ready);
  modport sink   (input valid, prediction, weight_sum, trained, output ready);
endinterface

interface hpbp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/hpbp_ram.sv
// ----------------------------------------------------------------------------
// hpbp_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hpbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hpbp_ctrl.sv
// ----------------------------------------------------------------------------
// hpbp_ctrl
// Sequencer: clearing sweep, then accept, read, sum and commit per request.
// ----------------------------------------------------------------------------
module hpbp_ctrl import hpbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Decode state into commands
  always_comb begin
    state_next   = state;
    req_ready    = 1'b0;
    cmd          = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/hpbp_dp.sv
// ----------------------------------------------------------------------------
// hpbp_dp
// Datapath: hash indexes, weight banks, sum, training, history, result.
// ----------------------------------------------------------------------------
module hpbp_dp import hpbp_pkg::*; #(
  parameter int unsigned ENTRIES_PER_TABLE = 1024,
  parameter int unsigned TABLE_COUNT       = 8,
  parameter int unsigned WEIGHT_BITS       = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  input  logic        req_command,
  input  logic [63:0] req_branch_address,
  input  logic        req_taken,
  hpbp_rsp_if.source  rsp,
  hpbp_cfg_if.sink    cfg
);

  localparam int unsigned IW  = $clog2(ENTRIES_PER_TABLE);
  localparam int unsigned NB  = TABLE_COUNT + 2;  // bias, corrector, tables
  localparam int unsigned SW0 = WEIGHT_BITS + $clog2(NB) + 1;
  localparam int unsigned SW  = (SW0 > OUT_SUM_BITS) ? SW0 : OUT_SUM_BITS;
  localparam int unsigned CW  = ((WEIGHT_BITS > WMIN_BITS) ? WEIGHT_BITS : WMIN_BITS) + 1;
  localparam logic signed [CW-1:0] HI_REP = CW'((64'd1 << (WEIGHT_BITS - 1)) - 64'd1);
  localparam logic signed [CW-1:0] LO_REP = -HI_REP - CW'(1);
  localparam logic signed [SW-1:0] SUM_HI = SW'((64'd1 << (OUT_SUM_BITS - 1)) - 64'd1);
  localparam logic signed [SW-1:0] SUM_LO = -SUM_HI - SW'(1);

  // Configuration registers
  logic [THRESHOLD_BITS-1:0] train_threshold;
  logic [WMAX_BITS-1:0]      weight_max;
  logic [WMIN_BITS-1:0]      weight_min;

  // Request and state registers
  logic        upd;
  logic        tkn;
  logic [63:0] history;
  logic [IW-1:0] idx [NB];
  logic [IW-1:0] clr_cnt;
  logic signed [SW-1:0] sum_q;

  logic [WEIGHT_BITS-1:0] rdata [NB];
  logic [WEIGHT_BITS-1:0] wdata [NB];
  logic [IW-1:0]          hash  [NB];

  logic signed [SW-1:0] sum_c;
  logic [SW-1:0]        mag;
  logic                 pred;
  logic                 train;
  logic                 we;
  logic signed [CW-1:0] hi_lim;
  logic signed [CW-1:0] lo_lim;
  logic signed [CW-1:0] wmax_s;
  logic signed [CW-1:0] wmin_s;
  logic [63:0]          hist_a;
  logic [63:0]          hist_b;

  assign cfg.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      train_threshold <= THRESHOLD_RESET;
      weight_max      <= WMAX_RESET;
      weight_min      <= WMIN_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_TRAIN_THRESHOLD: train_threshold <= cfg.data[THRESHOLD_BITS-1:0];
        REG_WEIGHT_MAX:      weight_max      <= cfg.data[WMAX_BITS-1:0];
        REG_WEIGHT_MIN:      weight_min      <= cfg.data[WMIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Hash each bank's index: bias from address alone, the others from address and history
  assign hash[0] = req_branch_address[IW-1:0];
  assign hash[1] = IW'(req_branch_address ^ history ^ (CORRECTOR_ID * HASH_MUL));

  for (genvar t = 0; t < TABLE_COUNT; t++) begin : g_hash
    localparam logic [63:0] KEY = 64'(t) * HASH_MUL;
    assign hash[t+2] = IW'(req_branch_address ^ history ^ KEY);
  end

  // Capture request and indexes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      upd <= (req_command == CMD_UPDATE);
      tkn <= req_taken;
      for (int b = 0; b < NB; b++) begin
        idx[b] <= hash[b];
      end
    end
  end

  // Sweep counter for clearing after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_we) begin
      clr_cnt <= clr_cnt + IW'(1);
    end
  end
  assign status.clear_last = (clr_cnt == {IW{1'b1}});

  // Sum all selected weights
  always_comb begin
    sum_c = '0;
    for (int b = 0; b < NB; b++) begin
      sum_c = sum_c + SW'($signed(rdata[b]));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      sum_q <= sum_c;
    end
  end

  // Training decision
  assign pred  = ~sum_q[SW-1];
  assign mag   = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
  assign train = upd &&
                 ((pred != tkn) || (mag < {{(SW-THRESHOLD_BITS){1'b0}}, train_threshold}));
  assign we    = cmd.clear_we || (cmd.commit && train);

  // Effective clamp limits
  assign wmax_s = CW'($signed({1'b0, weight_max}));
  assign wmin_s = CW'($signed(weight_min));
  assign hi_lim = (wmax_s < HI_REP) ? wmax_s : HI_REP;
  assign lo_lim = (wmin_s > LO_REP) ? wmin_s : LO_REP;

  // Step and clamp each weight, instantiate banks
  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic signed [CW-1:0] v;
    logic signed [CW-1:0] v_hi;
    logic signed [CW-1:0] v_cl;

    assign v    = CW'($signed(rdata[b])) + (tkn ? CW'(1) : -CW'(1));
    assign v_hi = (v > hi_lim) ? hi_lim : v;
    assign v_cl = (v_hi < lo_lim) ? lo_lim : v_hi;
    assign wdata[b] = cmd.clear_we ? '0 : v_cl[WEIGHT_BITS-1:0];

    hpbp_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (ENTRIES_PER_TABLE)
    ) u_ram (
      .clk   (clk),
      .we    (we),
      .waddr (cmd.clear_we ? clr_cnt : idx[b]),
      .wdata (wdata[b]),
      .raddr (idx[b]),
      .rdata (rdata[b])
    );
  end

  // Advance folded history on update
  assign hist_a = history ^ (history << HIST_SHL);
  assign hist_b = hist_a ^ (hist_a >> HIST_SHR) ^ (tkn ? HASH_MUL : 64'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (cmd.commit && upd) begin
      history <= hist_b;
    end
  end

  // Result register
  assign status.out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.prediction <= pred;
      rsp.trained    <= train;
      if (sum_q > SUM_HI) begin
        rsp.weight_sum <= SUM_HI[OUT_SUM_BITS-1:0];
      end else if (sum_q < SUM_LO) begin
        rsp.weight_sum <= SUM_LO[OUT_SUM_BITS-1:0];
      end else begin
        rsp.weight_sum <= sum_q[OUT_SUM_BITS-1:0];
      end
    end
  end

endmodule

FILE: rtl/hashed_perceptron_branch_predictor_core.sv
// ----------------------------------------------------------------------------
// hashed_perceptron_branch_predictor_core
// Top level: sequencer and datapath of the hashed perceptron predictor.
// ----------------------------------------------------------------------------
// After reset the block sweeps every weight bank to zero, one entry per cycle;
// configuration writes are taken during the sweep, requests are not. Each
// request then passes through capture and hash, bank read, sum, and train and
// commit, and the block handles one request at a time: it takes no new
// request until the previous one has committed. The result waits in an
// output register; a stalled result holds the commit step until the
// register frees. All TABLE_COUNT + 2 weight banks are read and written in
// parallel.
module hashed_perceptron_branch_predictor_core import hpbp_pkg::*; #(
  parameter int unsigned ENTRIES_PER_TABLE = 1024,
  parameter int unsigned TABLE_COUNT       = 8,
  parameter int unsigned WEIGHT_BITS       = 8
) (
  input logic        clk,
  input logic        rst,
  hpbp_req_if.sink   req,
  hpbp_rsp_if.source rsp,
  hpbp_cfg_if.sink   cfg
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       ctrl_ready;

  assign req.ready = ctrl_ready;

  hpbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ctrl_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hpbp_dp #(
    .ENTRIES_PER_TABLE (ENTRIES_PER_TABLE),
    .TABLE_COUNT       (TABLE_COUNT),
    .WEIGHT_BITS       (WEIGHT_BITS)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .req_command        (req.command),
    .req_branch_address (req.branch_address),
    .req_taken          (req.taken),
    .rsp                (rsp),
    .cfg                (cfg)
  );

  // No transaction accepted while the banks are being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_we |-> !(req.valid && req.ready))
    else $error("request accepted during clearing sweep");

  // Commit only into a free result register
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("commit while result register busy");

  // One request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while previous one in flight");

  // A commit presents a result
  a_commit_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp.valid)
    else $error("commit without result");

endmodule
